@@ hdl/master_slave_pid_sync_assert.svh @@
// Assertion macros shared by the RTL; clock is clk, reset is arst_n.
`ifndef MASTER_SLAVE_PID_SYNC_ASSERT_SVH
`define MASTER_SLAVE_PID_SYNC_ASSERT_SVH

// cond holds at every clock edge out of reset
`define MSPS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// ante at one edge implies cons at the same edge
`define MSPS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// ante at one edge implies cons at the next edge
`define MSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/msps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package msps_pkg;

	localparam int GAIN_FRACTION_BITS_DEF = 8;
	localparam int POSITION_WIDTH_DEF     = 32;

	localparam int CFG_DATA_WIDTH  = 16;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int GAIN_WIDTH      = 16;
	localparam int FIELD_WIDTH     = 32;

	localparam int MINT_WIDTH = 11;
	localparam int SINT_WIDTH = 10;

	localparam int MASTER_INT_LIMIT = 1000;
	localparam int SLAVE_INT_LIMIT  = 500;
	localparam int DUTY_MAX         = 255;
	localparam int SCMD_MAX         = 32767;
	localparam int SCMD_MIN         = -32768;

	localparam logic [7:0] SPEED_LIMIT_RESET = 8'd255;
	localparam logic [9:0] DEADBAND_RESET    = 10'd10;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MASTER_KP   = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MASTER_KI   = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MASTER_KD   = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLAVE_KP    = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLAVE_KI    = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLAVE_KD    = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPEED_LIMIT = 3'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEADBAND    = 3'd7;

	typedef logic signed [GAIN_WIDTH-1:0] gain_t;

endpackage

`default_nettype wire

@@ hdl/master_slave_pid_sync.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Master/slave position sync controller. Every accepted input word is one control tick;
// a tick with sync_enable low only applies clear_history and gives no output word. Each
// enabled tick gives exactly one output word, in order. A word taken into the input register
// reaches the output register through the error/integral, multiplier, sum and command stages.
// One word is accepted every cycle, and the whole pipeline stalls only while the output register
// holds a word that is not taken.
// Gains are signed Q8.8 (GAIN_FRACTION_BITS); positions use their low POSITION_WIDTH bits.
// Write configuration only while no tick is in flight.
module master_slave_pid_sync
	import msps_pkg::*;
#(
	parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF,
	parameter int POSITION_WIDTH     = POSITION_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// target_position, master_position, slave_position
	input  wire logic [3*FIELD_WIDTH-1:0]   s_tdata,
	// sync_enable, clear_history
	input  wire logic [1:0]                 s_tuser,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// master_command, slave_command, master_enable, master_reverse, master_duty,
	// slave_enable, slave_reverse, slave_duty, 3 zero bits
	output logic [47:0]                     m_tdata
);

	localparam int PW = POSITION_WIDTH;
	localparam int DW = PW + 1;
	localparam int MW = PW + 19;
	localparam int SW = MW + 1;
	localparam int PPW = PW + GAIN_WIDTH;
	localparam int PDW = DW + GAIN_WIDTH;
	localparam int PMIW = MINT_WIDTH + GAIN_WIDTH;
	localparam int PSIW = SINT_WIDTH + GAIN_WIDTH;
	localparam logic signed [MW-1:0] TBIAS_M = MW'((64'd1 << GAIN_FRACTION_BITS) - 64'd1);
	localparam logic signed [SW-1:0] TBIAS_S = SW'((64'd1 << GAIN_FRACTION_BITS) - 64'd1);
	localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

	// configuration
	gain_t mkp_q, mki_q, mkd_q, skp_q, ski_q, skd_q;
	logic [7:0] speed_limit_q;
	logic [9:0] deadband_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mkp_q <= '0;
			mki_q <= '0;
			mkd_q <= '0;
			skp_q <= '0;
			ski_q <= '0;
			skd_q <= '0;
			speed_limit_q <= SPEED_LIMIT_RESET;
			deadband_q <= DEADBAND_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MASTER_KP:   mkp_q <= cfg_data;
				REG_MASTER_KI:   mki_q <= cfg_data;
				REG_MASTER_KD:   mkd_q <= cfg_data;
				REG_SLAVE_KP:    skp_q <= cfg_data;
				REG_SLAVE_KI:    ski_q <= cfg_data;
				REG_SLAVE_KD:    skd_q <= cfg_data;
				REG_SPEED_LIMIT: speed_limit_q <= cfg_data[7:0];
				REG_DEADBAND:    deadband_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	logic out_valid_q;
	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	assign en = !out_valid_q || m_tready;
	assign s_tready = en;

	// stage 1: input register
	logic sync_s1, clr_s1;
	logic signed [PW-1:0] tgt_s1, mpos_s1, spos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && s_tvalid) begin
			sync_s1 <= s_tuser[0];
			clr_s1 <= s_tuser[1];
			tgt_s1 <= s_tdata[PW-1:0];
			mpos_s1 <= s_tdata[FIELD_WIDTH+PW-1:FIELD_WIDTH];
			spos_s1 <= s_tdata[2*FIELD_WIDTH+PW-1:2*FIELD_WIDTH];
		end
	end

	// controller history
	logic signed [MINT_WIDTH-1:0] mint_q;
	logic signed [SINT_WIDTH-1:0] sint_q;
	logic signed [PW-1:0] mprev_q, sprev_q;

	logic signed [DW-1:0] m_diff, s_diff;
	logic signed [PW-1:0] m_err_raw, m_err, s_err;
	logic [PW-1:0] m_mag;
	logic in_db;
	logic signed [MINT_WIDTH-1:0] mint_b, mint_new;
	logic signed [SINT_WIDTH-1:0] sint_b, sint_new;
	logic signed [PW-1:0] mprev_b, sprev_b;
	logic signed [DW-1:0] mint_sum, sint_sum, m_der, s_der;

	always_comb begin
		m_diff = DW'(tgt_s1) - DW'(mpos_s1);
		s_diff = DW'(mpos_s1) - DW'(spos_s1);
		if (m_diff[DW-1] != m_diff[DW-2]) begin
			m_err_raw = m_diff[DW-1] ? POS_MIN : POS_MAX;
		end else begin
			m_err_raw = m_diff[PW-1:0];
		end
		if (s_diff[DW-1] != s_diff[DW-2]) begin
			s_err = s_diff[DW-1] ? POS_MIN : POS_MAX;
		end else begin
			s_err = s_diff[PW-1:0];
		end
		m_mag = m_err_raw[PW-1] ? PW'(-m_err_raw) : PW'(m_err_raw);
		in_db = m_mag < PW'(deadband_q);
		m_err = in_db ? PW'(0) : m_err_raw;

		mint_b = (clr_s1 || in_db) ? MINT_WIDTH'(0) : mint_q;
		sint_b = clr_s1 ? SINT_WIDTH'(0) : sint_q;
		mprev_b = clr_s1 ? PW'(0) : mprev_q;
		sprev_b = clr_s1 ? PW'(0) : sprev_q;

		mint_sum = DW'(m_err) + DW'(mint_b);
		if (mint_sum > DW'(MASTER_INT_LIMIT)) begin
			mint_new = MINT_WIDTH'(MASTER_INT_LIMIT);
		end else if (mint_sum < DW'(-MASTER_INT_LIMIT)) begin
			mint_new = MINT_WIDTH'(-MASTER_INT_LIMIT);
		end else begin
			mint_new = mint_sum[MINT_WIDTH-1:0];
		end
		sint_sum = DW'(s_err) + DW'(sint_b);
		if (sint_sum > DW'(SLAVE_INT_LIMIT)) begin
			sint_new = SINT_WIDTH'(SLAVE_INT_LIMIT);
		end else if (sint_sum < DW'(-SLAVE_INT_LIMIT)) begin
			sint_new = SINT_WIDTH'(-SLAVE_INT_LIMIT);
		end else begin
			sint_new = sint_sum[SINT_WIDTH-1:0];
		end
		m_der = DW'(m_err) - DW'(mprev_b);
		s_der = DW'(s_err) - DW'(sprev_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mint_q <= '0;
			sint_q <= '0;
			mprev_q <= '0;
			sprev_q <= '0;
		end else if (en && v_s1) begin
			if (sync_s1) begin
				mint_q <= mint_new;
				sint_q <= sint_new;
				mprev_q <= m_err;
				sprev_q <= s_err;
			end else if (clr_s1) begin
				mint_q <= '0;
				sint_q <= '0;
				mprev_q <= '0;
				sprev_q <= '0;
			end
		end
	end

	// stage 2: gain products
	logic signed [PW-1:0] m_err_s2, s_err_s2;
	logic signed [MINT_WIDTH-1:0] mint_s2;
	logic signed [SINT_WIDTH-1:0] sint_s2;
	logic signed [DW-1:0] m_der_s2, s_der_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && sync_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1 && sync_s1) begin
			m_err_s2 <= m_err;
			s_err_s2 <= s_err;
			mint_s2 <= mint_new;
			sint_s2 <= sint_new;
			m_der_s2 <= m_der;
			s_der_s2 <= s_der;
		end
	end

	logic signed [PPW-1:0] mp_p, sp_p;
	logic signed [PMIW-1:0] mp_i;
	logic signed [PSIW-1:0] sp_i;
	logic signed [PDW-1:0] mp_d, sp_d;

	assign mp_p = m_err_s2 * mkp_q;
	assign mp_i = mint_s2 * mki_q;
	assign mp_d = m_der_s2 * mkd_q;
	assign sp_p = s_err_s2 * skp_q;
	assign sp_i = sint_s2 * ski_q;
	assign sp_d = s_der_s2 * skd_q;

	// stage 3: sums, master truncation
	logic signed [PPW-1:0] mp_p_s3, sp_p_s3;
	logic signed [PMIW-1:0] mp_i_s3;
	logic signed [PSIW-1:0] sp_i_s3;
	logic signed [PDW-1:0] mp_d_s3, sp_d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s2) begin
			mp_p_s3 <= mp_p;
			mp_i_s3 <= mp_i;
			mp_d_s3 <= mp_d;
			sp_p_s3 <= sp_p;
			sp_i_s3 <= sp_i;
			sp_d_s3 <= sp_d;
		end
	end

	logic signed [MW-1:0] m_sum, m_bias, m_rnd, m_tr, s_sum;

	always_comb begin
		m_sum = MW'(mp_p_s3) + MW'(mp_i_s3) + MW'(mp_d_s3);
		s_sum = MW'(sp_p_s3) + MW'(sp_i_s3) + MW'(sp_d_s3);
		// bias negative sums so the shift rounds toward zero
		m_bias = m_sum[MW-1] ? TBIAS_M : MW'(0);
		m_rnd = m_sum + m_bias;
		m_tr = m_rnd >>> GAIN_FRACTION_BITS;
	end

	// stage 4: command limits and drive outputs
	logic signed [MW-1:0] m_tr_s4, s_sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s3) begin
			m_tr_s4 <= m_tr;
			s_sum_s4 <= s_sum;
		end
	end

	logic signed [8:0] lim9, mcmd, m_abs;
	logic signed [SW-1:0] s_tot, s_bias, s_rnd, s_tr;
	logic signed [15:0] scmd;
	logic signed [16:0] scmd17;
	logic [16:0] s_abs;
	logic m_on, s_on;
	logic [7:0] m_duty, s_duty;

	always_comb begin
		lim9 = $signed({1'b0, speed_limit_q});
		if (m_tr_s4 > MW'(lim9)) begin
			mcmd = lim9;
		end else if (m_tr_s4 < MW'(-lim9)) begin
			mcmd = -lim9;
		end else begin
			mcmd = m_tr_s4[8:0];
		end
		s_tot = (SW'(mcmd) <<< GAIN_FRACTION_BITS) + SW'(s_sum_s4);
		s_bias = s_tot[SW-1] ? TBIAS_S : SW'(0);
		s_rnd = s_tot + s_bias;
		s_tr = s_rnd >>> GAIN_FRACTION_BITS;
		if (s_tr > SW'(SCMD_MAX)) begin
			scmd = 16'(SCMD_MAX);
		end else if (s_tr < SW'(SCMD_MIN)) begin
			scmd = 16'(SCMD_MIN);
		end else begin
			scmd = s_tr[15:0];
		end
		m_abs = mcmd[8] ? -mcmd : mcmd;
		m_duty = m_abs[7:0];
		m_on = mcmd != 9'sd0;
		s_on = !(scmd == 16'sd0 && mcmd == 9'sd0);
		scmd17 = 17'(scmd);
		s_abs = scmd[15] ? 17'(-scmd17) : 17'(scmd17);
		if (!s_on) begin
			s_duty = 8'd0;
		end else if (s_abs > 17'(DUTY_MAX)) begin
			s_duty = 8'(DUTY_MAX);
		end else begin
			s_duty = s_abs[7:0];
		end
	end

	// output register
	logic signed [8:0] mcmd_q;
	logic signed [15:0] scmd_q;
	logic m_on_q, m_rev_q, s_on_q, s_rev_q;
	logic [7:0] m_duty_q, s_duty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s4) begin
			mcmd_q <= mcmd;
			scmd_q <= scmd;
			m_on_q <= m_on;
			m_rev_q <= mcmd[8];
			m_duty_q <= m_duty;
			s_on_q <= s_on;
			s_rev_q <= scmd[15] || (scmd == 16'sd0);
			s_duty_q <= s_duty;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'b000, s_duty_q, s_rev_q, s_on_q, m_duty_q, m_rev_q, m_on_q,
		scmd_q, mcmd_q};

`include "master_slave_pid_sync_assert.svh"

	`MSPS_ASSERT_ALWAYS(a_mint_range,
		mint_q <= MINT_WIDTH'(MASTER_INT_LIMIT) && mint_q >= MINT_WIDTH'(-MASTER_INT_LIMIT),
		"master integral out of range")
	`MSPS_ASSERT_ALWAYS(a_sint_range,
		sint_q <= SINT_WIDTH'(SLAVE_INT_LIMIT) && sint_q >= SINT_WIDTH'(-SLAVE_INT_LIMIT),
		"slave integral out of range")
	`MSPS_ASSERT_NEXT(a_clear_idle, en && v_s1 && clr_s1 && !sync_s1,
		mint_q == '0 && sint_q == '0 && mprev_q == '0 && sprev_q == '0,
		"clear on idle tick did not zero history")
	`MSPS_ASSERT_SAME(a_speed_limit, out_valid_q, m_duty_q <= speed_limit_q,
		"master duty above speed limit")
	`MSPS_ASSERT_SAME(a_slave_off, out_valid_q && !s_on_q,
		mcmd_q == 9'sd0 && scmd_q == 16'sd0 && s_duty_q == 8'd0,
		"slave disabled with nonzero command")

endmodule

`default_nettype wire

@@ tb/master_slave_pid_sync_test.sv @@
`timescale 1ns / 1ps

module master_slave_pid_sync_test;
	import msps_pkg::*;

	// m_tdata layout, lowest bits last
	typedef struct packed {
		logic [2:0]        pad;
		logic [7:0]        sduty;
		logic              srev;
		logic              sen;
		logic [7:0]        mduty;
		logic              mrev;
		logic              men;
		logic signed [15:0] scmd;
		logic signed [8:0]  mcmd;
	} drive_word_t;

	class drive_predictor;
		longint mkp, mki, mkd, skp, ski, skd, speed, dband;
		longint mint, mprev, sint, sprev;
		drive_word_t due[$];
		int errors;

		function new();
			mkp = 0; mki = 0; mkd = 0;
			skp = 0; ski = 0; skd = 0;
			speed = SPEED_LIMIT_RESET;
			dband = DEADBAND_RESET;
			errors = 0;
			clear();
		endfunction

		function void clear();
			mint = 0; mprev = 0; sint = 0; sprev = 0;
		endfunction

		static function longint clamp(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		static function longint drop_frac(longint s);
			if (s < 0)
				return -((-s) >> GAIN_FRACTION_BITS_DEF);
			return s >> GAIN_FRACTION_BITS_DEF;
		endfunction

		function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
			case (idx)
				REG_MASTER_KP:   mkp = longint'($signed(data));
				REG_MASTER_KI:   mki = longint'($signed(data));
				REG_MASTER_KD:   mkd = longint'($signed(data));
				REG_SLAVE_KP:    skp = longint'($signed(data));
				REG_SLAVE_KI:    ski = longint'($signed(data));
				REG_SLAVE_KD:    skd = longint'($signed(data));
				REG_SPEED_LIMIT: speed = longint'(data[7:0]);
				REG_DEADBAND:    dband = longint'(data[9:0]);
				default: ;
			endcase
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void note_tick(logic sync, logic clr, logic [FIELD_WIDTH-1:0] tgt,
				logic [FIELD_WIDTH-1:0] mpos, logic [FIELD_WIDTH-1:0] spos);
			longint lim, err, der, sum, mcmd, scmd, mag, tp, mp, sp;
			drive_word_t w;
			lim = longint'(1) << (POSITION_WIDTH_DEF - 1);
			if (clr)
				clear();
			if (!sync)
				return;
			tp = longint'($signed(tgt));
			mp = longint'($signed(mpos));
			sp = longint'($signed(spos));

			err = clamp(tp - mp, -lim, lim - 1);
			mag = err < 0 ? -err : err;
			if (mag < dband) begin
				err = 0;
				mint = 0;
			end
			mint = clamp(mint + err, -MASTER_INT_LIMIT, MASTER_INT_LIMIT);
			der = err - mprev;
			mprev = err;
			sum = err * mkp + mint * mki + der * mkd;
			mcmd = clamp(drop_frac(sum), -speed, speed);

			err = clamp(mp - sp, -lim, lim - 1);
			sint = clamp(sint + err, -SLAVE_INT_LIMIT, SLAVE_INT_LIMIT);
			der = err - sprev;
			sprev = err;
			sum = err * skp + sint * ski + der * skd;
			scmd = clamp(drop_frac((mcmd << GAIN_FRACTION_BITS_DEF) + sum), SCMD_MIN, SCMD_MAX);

			w.pad = '0;
			w.mcmd = mcmd[8:0];
			w.scmd = scmd[15:0];
			w.men = (mcmd != 0);
			w.mrev = (mcmd < 0);
			mag = mcmd < 0 ? -mcmd : mcmd;
			w.mduty = mag[7:0];
			w.sen = !(scmd == 0 && mcmd == 0);
			w.srev = (scmd <= 0);
			mag = scmd < 0 ? -scmd : scmd;
			if (mag > DUTY_MAX)
				mag = DUTY_MAX;
			w.sduty = w.sen ? mag[7:0] : 8'd0;
			due.push_back(w);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			if (errors <= 40)
				$display("%0t: mismatch %s: got %0h want %0h", $time, what, got, want);
		endtask

		task check_drive(logic [47:0] raw);
			drive_word_t got, want;
			got = drive_word_t'(raw);
			if (due.size() == 0) begin
				report("word with nothing due", raw, 0);
				return;
			end
			want = due.pop_front();
			if (got.mcmd !== want.mcmd)   report("master_command", got.mcmd, want.mcmd);
			if (got.scmd !== want.scmd)   report("slave_command", got.scmd, want.scmd);
			if (got.men !== want.men)     report("master_enable", got.men, want.men);
			if (got.mrev !== want.mrev)   report("master_reverse", got.mrev, want.mrev);
			if (got.mduty !== want.mduty) report("master_duty", got.mduty, want.mduty);
			if (got.sen !== want.sen)     report("slave_enable", got.sen, want.sen);
			if (got.srev !== want.srev)   report("slave_reverse", got.srev, want.srev);
			if (got.sduty !== want.sduty) report("slave_duty", got.sduty, want.sduty);
			if (got.pad !== want.pad)     report("pad bits", got.pad, want.pad);
		endtask
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [3*FIELD_WIDTH-1:0]   s_tdata = '0;
	logic [1:0]                 s_tuser = '0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [47:0]                m_tdata;

	int send_idle = 0;
	int stall_pct = 0;
	drive_predictor sb = new();

	master_slave_pid_sync dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_drive(m_tdata);
	end

	initial begin
		#10000000;
		$display("** master_slave_pid_sync: FAILED **");
		$finish;
	end

	task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
	endtask

	task automatic load_settings(logic [15:0] mkp, logic [15:0] mki, logic [15:0] mkd,
			logic [15:0] skp, logic [15:0] ski, logic [15:0] skd,
			logic [7:0] speed, logic [9:0] dband);
		write_reg(REG_MASTER_KP, mkp);
		write_reg(REG_MASTER_KI, mki);
		write_reg(REG_MASTER_KD, mkd);
		write_reg(REG_SLAVE_KP, skp);
		write_reg(REG_SLAVE_KI, ski);
		write_reg(REG_SLAVE_KD, skd);
		write_reg(REG_SPEED_LIMIT, {8'($urandom), speed});
		write_reg(REG_DEADBAND, {6'($urandom), dband});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_tick(logic sync, logic clr, logic [31:0] t, logic [31:0] m,
			logic [31:0] s);
		int gap;
		gap = 0;
		while (gap < 300 && $urandom_range(99) < send_idle)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= {$urandom, $urandom, $urandom};
			s_tuser <= 2'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {s, m, t};
		s_tuser <= {clr, sync};
		do @(posedge clk); while (!s_tready);
		sb.note_tick(sync, clr, t, m, s);
	endtask

	// hold the sender off until every due word is out and the pipe is empty
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [31:0] extreme_pos();
		case ($urandom_range(4))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0000_0001;
			3: return 32'h7FFF_FFFF;
			default: return 32'h8000_0000;
		endcase
	endfunction

	function automatic logic [31:0] near(logic [31:0] base, int r);
		return base + ($urandom_range(2 * r) - r);
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3, 4: return 16'($urandom);
			default: return 16'($urandom_range(1024) - 512);
		endcase
	endfunction

	task automatic random_tick(output logic sync, output logic clr, output logic [31:0] t,
			output logic [31:0] m, output logic [31:0] s);
		int unsigned mode;
		sync = ($urandom_range(99) < 88);
		clr = ($urandom_range(99) < 4);
		mode = $urandom_range(99);
		if (mode < 70) begin
			m = $urandom;
			t = near(m, ($urandom_range(3) == 0) ? 16 : 3000);
			s = near(m, 900);
		end else if (mode < 85) begin
			t = $urandom;
			m = $urandom;
			s = $urandom;
		end else begin
			t = extreme_pos();
			m = extreme_pos();
			s = extreme_pos();
		end
	endtask

	initial begin
		logic sync, clr;
		logic [31:0] t, m, s;
		int sent;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle = 10;
		stall_pct = 10;

		// reset settings: zero gains, deadband 10, limit 255
		send_tick(1'b1, 1'b0, 32'd0, 32'd0, 32'd0);
		send_tick(1'b1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
		send_tick(1'b0, 1'b0, 32'd100, 32'd0, 32'd0);
		send_tick(1'b0, 1'b1, 32'd100, 32'd0, 32'd0);
		settle();

		load_settings(16'd256, 16'd16, 16'd64, 16'd128, 16'd8, 16'd32, 8'd200, 10'd10);
		send_tick(1'b1, 1'b1, 32'd100, 32'd0, 32'd0);
		send_tick(1'b1, 1'b0, 32'd9, 32'd0, 32'd0);
		send_tick(1'b1, 1'b0, 32'd10, 32'd0, 32'd0);
		send_tick(1'b1, 1'b0, -32'sd10, 32'd0, 32'd0);
		send_tick(1'b1, 1'b0, -32'sd9, 32'd0, 32'd0);
		send_tick(1'b1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		send_tick(1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_tick(1'b1, 1'b0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		repeat (4) send_tick(1'b1, 1'b0, 32'd5000, 32'd0, -32'sd3000);
		send_tick(1'b0, 1'b1, 32'd5, 32'd6, 32'd7);
		send_tick(1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_tick(1'b1, 1'b0, -32'sd500, 32'd0, 32'd0);
		send_tick(1'b1, 1'b1, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678);
		send_tick(1'b1, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'd0);
		send_tick(1'b0, 1'b0, 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h5555_AAAA);

		for (int p = 0; p < 8; p++) begin
			settle();
			case (p % 4)
				0: begin send_idle = 0;  stall_pct = 0;  end
				1: begin send_idle = 86; stall_pct = 0;  end
				2: begin send_idle = 0;  stall_pct = 86; end
				default: begin send_idle = 10; stall_pct = 10; end
			endcase
			if (p == 0)
				load_settings(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
					8'd255, 10'd1023);
			else if (p == 7)
				load_settings(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
					8'd0, 10'd0);
			else
				load_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
					pick_gain(),
					($urandom_range(3) == 0) ? 8'($urandom_range(1) * 255) : 8'($urandom),
					($urandom_range(3) == 0) ? 10'($urandom_range(1) * 1023)
						: 10'($urandom_range(64)));
			sent = 0;
			while (sent < 106) begin
				random_tick(sync, clr, t, m, s);
				send_tick(sync, clr, t, m, s);
				sent++;
				if (sent == 53)
					settle();
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("** master_slave_pid_sync: PASSED **");
		else
			$display("** master_slave_pid_sync: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/msps_pkg.sv
hdl/master_slave_pid_sync.sv
tb/master_slave_pid_sync_test.sv
